@@ hw/rtl/rhfb_pkg.sv @@
// ----------------------------------------------------------------------------
// rhfb_pkg
// Shared types and constants of the density and Fock matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

package rhfb_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 4;
  localparam int ACC_W  = 74;
  localparam int FRAC_W = 16;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic [1:0] OP_COEF      = 2'd0;
  localparam logic [1:0] OP_ONE_BODY  = 2'd1;
  localparam logic [1:0] OP_INTEGRAL  = 2'd2;
  localparam logic [1:0] OP_COMPUTE   = 2'd3;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SPATIAL  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OCCUPIED = 1'b1;

  localparam logic [CNT_W-1:0] SPATIAL_RESET  = 4'd8;
  localparam logic [CNT_W-1:0] OCCUPIED_RESET = 4'd1;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             dens;
    logic             diag;
    logic             final_entry;
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] y;
  } token_t;

endpackage

`default_nettype wire

@@ hw/rtl/rhfb_coef_mem.sv @@
// ----------------------------------------------------------------------------
// rhfb_coef_mem
// Coefficient store: one write port, two registered read ports; entries not
// yet written read as the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module rhfb_coef_mem #(
  parameter int MAX_ORBITALS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               we,
  input  wire logic [IW-1:0]                      wr_row,
  input  wire logic [IW-1:0]                      wr_col,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0] wr_data,
  input  wire logic [IW-1:0]                      rd_row0,
  input  wire logic [IW-1:0]                      rd_col0,
  input  wire logic [IW-1:0]                      rd_row1,
  input  wire logic [IW-1:0]                      rd_col1,
  output logic signed [rhfb_pkg::DATA_W-1:0]      rd_data0,
  output logic signed [rhfb_pkg::DATA_W-1:0]      rd_data1
);

  localparam int IW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

  logic signed [rhfb_pkg::DATA_W-1:0] mem [MAX_ORBITALS][MAX_ORBITALS];
  logic [MAX_ORBITALS-1:0]            written [MAX_ORBITALS];
  logic signed [rhfb_pkg::DATA_W-1:0] mem_q0;
  logic signed [rhfb_pkg::DATA_W-1:0] mem_q1;
  logic                               valid_q0;
  logic                               valid_q1;
  logic                               diag_q0;
  logic                               diag_q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORBITALS; i++) begin
        written[i] <= '0;
      end
    end else if (we) begin
      written[wr_row][wr_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_row][wr_col] <= wr_data;
    end
    mem_q0   <= mem[rd_row0][rd_col0];
    mem_q1   <= mem[rd_row1][rd_col1];
    valid_q0 <= written[rd_row0][rd_col0];
    valid_q1 <= written[rd_row1][rd_col1];
    diag_q0  <= (rd_row0 == rd_col0);
    diag_q1  <= (rd_row1 == rd_col1);
  end

  assign rd_data0 = valid_q0 ? mem_q0 : (diag_q0 ? rhfb_pkg::ONE_Q16 : '0);
  assign rd_data1 = valid_q1 ? mem_q1 : (diag_q1 ? rhfb_pkg::ONE_Q16 : '0);

endmodule

`default_nettype wire

@@ hw/rtl/rhfb_int_mem.sv @@
// ----------------------------------------------------------------------------
// rhfb_int_mem
// Two-body integral store <qr|w|ps>: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rhfb_int_mem #(
  parameter int MAX_ORBITALS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [IW-1:0]                      wr_q,
  input  wire logic [IW-1:0]                      wr_r,
  input  wire logic [IW-1:0]                      wr_p,
  input  wire logic [IW-1:0]                      wr_s,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0] wr_data,
  input  wire logic [IW-1:0]                      rd_q,
  input  wire logic [IW-1:0]                      rd_r,
  input  wire logic [IW-1:0]                      rd_p,
  input  wire logic [IW-1:0]                      rd_s,
  output logic signed [rhfb_pkg::DATA_W-1:0]      rd_data
);

  localparam int IW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

  logic signed [rhfb_pkg::DATA_W-1:0]
    mem [MAX_ORBITALS][MAX_ORBITALS][MAX_ORBITALS][MAX_ORBITALS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_q][wr_r][wr_p][wr_s] <= wr_data;
    end
    rd_data <= mem[rd_q][rd_r][rd_p][rd_s];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rhfb_mac.sv @@
// ----------------------------------------------------------------------------
// rhfb_mac
// Shared multiply-accumulate unit: product, exact wide accumulation, round
// half up to Q16.16 with optional doubling, and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rhfb_mac (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0] op_a,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0] op_b,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0] init,
  input  wire rhfb_pkg::token_t                   tk_in,
  output rhfb_pkg::token_t                        tk_out,
  output logic signed [rhfb_pkg::DATA_W-1:0]      result,
  output logic                                    active
);

  localparam int ACC_W = rhfb_pkg::ACC_W;
  localparam int RND_W = ACC_W - rhfb_pkg::FRAC_W;
  localparam int DW    = rhfb_pkg::DATA_W;

  rhfb_pkg::token_t           tka;
  rhfb_pkg::token_t           tkb;
  rhfb_pkg::token_t           tkc;
  logic signed [2*DW-1:0]     prod;
  logic signed [DW-1:0]       init_q;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [ACC_W-1:0]    base;
  logic signed [ACC_W-1:0]    scaled;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [RND_W-1:0]    rnd;
  logic                       ovf;

  always_comb begin
    base = tka.first ? {{(ACC_W-DW-rhfb_pkg::FRAC_W){init_q[DW-1]}}, init_q,
                        {rhfb_pkg::FRAC_W{1'b0}}} : acc;
    acc_next = base + {{(ACC_W-2*DW){prod[2*DW-1]}}, prod};
    scaled   = tkb.dens ? {acc[ACC_W-2:0], 1'b0} : acc;
    rounded  = scaled + {{(ACC_W-rhfb_pkg::FRAC_W){1'b0}}, 1'b1,
                         {(rhfb_pkg::FRAC_W-1){1'b0}}};
    ovf      = (rnd[RND_W-1:DW-1] != '0) && (rnd[RND_W-1:DW-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tka    <= '0;
      tkb    <= '0;
      tkc    <= '0;
      tk_out <= '0;
    end else begin
      tka          <= tk_in;
      tkb          <= tka;
      tkc          <= tkb;
      tkc.valid    <= tkb.valid && tkb.last;
      tk_out       <= tkc;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= op_a * op_b;
    init_q <= init;
    if (tka.valid) begin
      acc <= acc_next;
    end
    rnd <= rounded[ACC_W-1:rhfb_pkg::FRAC_W];
    if (ovf) begin
      result <= rnd[RND_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      result <= rnd[DW-1:0];
    end
  end

  assign active = tka.valid || tkb.valid || tkc.valid || tk_out.valid;

endmodule

`default_nettype wire

@@ hw/rtl/rhf_density_and_fock_build.sv @@
// ----------------------------------------------------------------------------
// rhf_density_and_fock_build
// Restricted Hartree-Fock density and Fock matrix build, signed Q16.16.
//
// Raise start with an opcode while busy is low to issue one transaction.
// Load transactions (coefficient, one-body diagonal, integral) are written at
// that edge and leave busy low. A compute transaction with a nonzero dimension
// raises busy, forms the density D(s,r) with N*N*max(occ,1) products, waits
// for the pipeline to drain, then forms all N*N Fock entries with N^4 products
// on the one shared multiply-accumulate unit, one product per cycle.
// Each Fock entry appears on row, column, fock_value and last for exactly one
// cycle with result_valid high, row by row; last marks the final entry. The
// receiver cannot stall, so no result is held back.
// The user must write configuration (cfg_write, cfg_index, cfg_data) only
// while busy is low; the block itself does not enforce it.
// Reset returns the dimension to 8, the occupancy to 1, the coefficients to
// identity and the one-body diagonal to zero; integrals must be written first.
`default_nettype none

module rhf_density_and_fock_build #(
  parameter int MAX_ORBITALS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            opcode,
  input  wire logic [2:0]                            index_a,
  input  wire logic [2:0]                            index_b,
  input  wire logic [2:0]                            index_c,
  input  wire logic [2:0]                            index_d,
  input  wire logic signed [rhfb_pkg::DATA_W-1:0]    value,
  input  wire logic                                  cfg_write,
  input  wire logic [rhfb_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [rhfb_pkg::CNT_W-1:0]            cfg_data,
  output logic                                       result_valid,
  output logic [2:0]                                 row,
  output logic [2:0]                                 column,
  output logic signed [rhfb_pkg::DATA_W-1:0]         fock_value,
  output logic                                       last
);

  localparam int IW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
  localparam int CW = rhfb_pkg::CNT_W;
  localparam int DW = rhfb_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DENS,
    ST_DRAIN,
    ST_FOCK,
    ST_FLUSH
  } state_t;

  state_t                state;
  logic [CW-1:0]         spatial_orbitals;
  logic [CW-1:0]         occupied_orbitals;
  logic [CW-1:0]         n;
  logic [CW-1:0]         jn;
  logic                  occ_zero;
  logic [CW-1:0]         cx;
  logic [CW-1:0]         cy;
  logic [CW-1:0]         cz;
  logic [CW-1:0]         cw;
  rhfb_pkg::token_t      tk0;
  rhfb_pkg::token_t      tk1;
  rhfb_pkg::token_t      tkd;

  logic                  accept;
  logic                  idx_ab_ok;
  logic                  idx_cd_ok;
  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         occ_eff;
  logic                  x_end;
  logic                  y_end;
  logic                  z_end;
  logic                  w_end;
  logic                  jz_end;
  logic                  mac_active;

  logic signed [DW-1:0]  h_store [MAX_ORBITALS];
  logic signed [DW-1:0]  dmem [MAX_ORBITALS][MAX_ORBITALS];
  logic signed [DW-1:0]  dens_rd;
  logic signed [DW-1:0]  coef_rd0;
  logic signed [DW-1:0]  coef_rd1;
  logic signed [DW-1:0]  int_rd;
  logic signed [DW-1:0]  op_a;
  logic signed [DW-1:0]  op_b;
  logic signed [DW-1:0]  init;
  logic signed [DW-1:0]  mac_result;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign idx_ab_ok = (32'(index_a) < MAX_ORBITALS) && (32'(index_b) < MAX_ORBITALS);
  assign idx_cd_ok = (32'(index_c) < MAX_ORBITALS) && (32'(index_d) < MAX_ORBITALS);

  assign n_eff   = (32'(spatial_orbitals) > MAX_ORBITALS) ? CW'(MAX_ORBITALS)
                                                          : spatial_orbitals;
  assign occ_eff = (occupied_orbitals > n_eff) ? n_eff : occupied_orbitals;

  assign x_end  = (cx == n - 1'b1);
  assign y_end  = (cy == n - 1'b1);
  assign z_end  = (cz == n - 1'b1);
  assign w_end  = (cw == n - 1'b1);
  assign jz_end = (cz == jn - 1'b1);

  always_comb begin
    tk0   = '0;
    tk0.x = cx;
    tk0.y = cy;
    case (state)
      ST_DENS: begin
        tk0.valid = 1'b1;
        tk0.dens  = 1'b1;
        tk0.first = (cz == '0);
        tk0.last  = jz_end;
      end
      ST_FOCK: begin
        tk0.valid       = 1'b1;
        tk0.first       = (cz == '0) && (cw == '0);
        tk0.last        = z_end && w_end;
        tk0.diag        = (cx == cy);
        tk0.final_entry = x_end && y_end;
      end
      default: begin
        tk0.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      spatial_orbitals  <= rhfb_pkg::SPATIAL_RESET;
      occupied_orbitals <= rhfb_pkg::OCCUPIED_RESET;
      tk1               <= '0;
    end else begin
      tk1 <= tk0;
      if (cfg_write) begin
        case (cfg_index)
          rhfb_pkg::REG_SPATIAL:  spatial_orbitals  <= cfg_data;
          rhfb_pkg::REG_OCCUPIED: occupied_orbitals <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept && opcode == rhfb_pkg::OP_COMPUTE && n_eff != '0) begin
            n        <= n_eff;
            jn       <= (occ_eff == '0) ? CW'(1) : occ_eff;
            occ_zero <= (occ_eff == '0);
            cx       <= '0;
            cy       <= '0;
            cz       <= '0;
            cw       <= '0;
            state    <= ST_DENS;
          end
        end
        ST_DENS: begin
          if (jz_end) begin
            cz <= '0;
            if (x_end) begin
              cx <= '0;
              if (y_end) begin
                cy    <= '0;
                state <= ST_DRAIN;
              end else begin
                cy <= cy + 1'b1;
              end
            end else begin
              cx <= cx + 1'b1;
            end
          end else begin
            cz <= cz + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!tk1.valid && !mac_active) begin
            state <= ST_FOCK;
          end
        end
        ST_FOCK: begin
          if (w_end) begin
            cw <= '0;
            if (z_end) begin
              cz <= '0;
              if (y_end) begin
                cy <= '0;
                if (x_end) begin
                  cx    <= '0;
                  state <= ST_FLUSH;
                end else begin
                  cx <= cx + 1'b1;
                end
              end else begin
                cy <= cy + 1'b1;
              end
            end else begin
              cz <= cz + 1'b1;
            end
          end else begin
            cw <= cw + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!tk1.valid && !mac_active) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORBITALS; i++) begin
        h_store[i] <= '0;
      end
    end else if (accept && opcode == rhfb_pkg::OP_ONE_BODY &&
                 32'(index_a) < MAX_ORBITALS) begin
      h_store[IW'(index_a)] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (tkd.valid && tkd.dens) begin
      dmem[IW'(tkd.x)][IW'(tkd.y)] <= mac_result;
    end
    dens_rd <= dmem[IW'(cw)][IW'(cz)];
  end

  rhfb_coef_mem #(
    .MAX_ORBITALS (MAX_ORBITALS)
  ) u_coef (
    .clk      (clk),
    .rst      (rst),
    .we       (accept && opcode == rhfb_pkg::OP_COEF && idx_ab_ok),
    .wr_row   (IW'(index_a)),
    .wr_col   (IW'(index_b)),
    .wr_data  (value),
    .rd_row0  (IW'(cx)),
    .rd_col0  (IW'(cz)),
    .rd_row1  (IW'(cy)),
    .rd_col1  (IW'(cz)),
    .rd_data0 (coef_rd0),
    .rd_data1 (coef_rd1)
  );

  rhfb_int_mem #(
    .MAX_ORBITALS (MAX_ORBITALS)
  ) u_int (
    .clk     (clk),
    .we      (accept && opcode == rhfb_pkg::OP_INTEGRAL && idx_ab_ok && idx_cd_ok),
    .wr_q    (IW'(index_a)),
    .wr_r    (IW'(index_b)),
    .wr_p    (IW'(index_c)),
    .wr_s    (IW'(index_d)),
    .wr_data (value),
    .rd_q    (IW'(cx)),
    .rd_r    (IW'(cz)),
    .rd_p    (IW'(cy)),
    .rd_s    (IW'(cw)),
    .rd_data (int_rd)
  );

  always_comb begin
    if (tk1.dens) begin
      op_a = occ_zero ? '0 : coef_rd0;
      op_b = coef_rd1;
      init = '0;
    end else begin
      op_a = dens_rd;
      op_b = int_rd;
      init = tk1.diag ? h_store[IW'(tk1.y)] : '0;
    end
  end

  rhfb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .op_a   (op_a),
    .op_b   (op_b),
    .init   (init),
    .tk_in  (tk1),
    .tk_out (tkd),
    .result (mac_result),
    .active (mac_active)
  );

  assign result_valid = tkd.valid && !tkd.dens;
  assign row          = tkd.x[2:0];
  assign column       = tkd.y[2:0];
  assign fock_value   = mac_result;
  assign last         = tkd.final_entry;

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a compute transaction");

  a_fock_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOCK) && ($past(state) == ST_DRAIN) |-> !mac_active && !tk1.valid)
    else $error("Fock products issued before density writes finished");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> !mac_active && !tk1.valid)
    else $error("block went idle with work in flight");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result after the final entry");

endmodule

`default_nettype wire
